// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Types and constants shared by the ARP responder and its IP-to-MAC cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN = 8'd6;

    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int ENT_W = IP_W + MAC_W;

    // configuration register indexes
    localparam logic CFG_STN_IP  = 1'b0;
    localparam logic CFG_STN_MAC = 1'b1;

    // command codes
    localparam logic CMD_PACKET  = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_LEARNED = 3'd1,
        ST_REPLY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_HIT     = 3'd4,
        ST_MISS    = 3'd5
    } t_status;

    typedef struct packed {
        logic              command;
        logic [15:0]       arp_opcode;
        logic [15:0]       hardware_type;
        logic [IP_W-1:0]   src_ip;
        logic [MAC_W-1:0]  src_mac;
        logic [IP_W-1:0]   dst_ip;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [MAC_W-1:0]  resolved_mac;
        logic [15:0]       reply_hardware_type;
        logic [MAC_W-1:0]  reply_target_mac;
        logic [IP_W-1:0]   reply_target_ip;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic hit;
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/arpc_ram.sv =====
// ----------------------------------------------------------------------------
// arpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/arpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: takes an item, runs the cache scan, then commits the result.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.skip || i_stat.hit || i_stat.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/arpc_dp.sv =====
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: item and config registers, cache table, scan, result register.
// ----------------------------------------------------------------------------
module arpc_dp
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [MAC_W-1:0] i_cfg_data,
    input  t_in_item         i_in_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    logic [IP_W-1:0]  r_stn_ip;
    logic [MAC_W-1:0] r_stn_mac;
    t_in_item         r_item;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_rd_idx;
    logic             r_cmp_vld;
    logic             r_found;
    logic [MAC_W-1:0] r_found_mac;
    logic             r_out_vld;
    t_out_item        r_out;

    logic [ENT_W-1:0] rd_data;
    logic [IP_W-1:0]  key;
    logic             for_us;
    logic             full;
    logic             issue;
    logic             hit;
    logic             wr_en;
    t_out_item        n_out;

    assign key    = (r_item.command == CMD_RESOLVE) ? r_item.dst_ip : r_item.src_ip;
    assign for_us = (r_item.dst_ip == r_stn_ip);
    assign full   = (r_count == FULL_COUNT);
    assign issue  = i_cmd.scan && (r_rd_idx < r_count);
    assign hit    = r_cmp_vld && (rd_data[ENT_W-1:MAC_W] == key);
    assign wr_en  = i_cmd.commit && (r_item.command == CMD_PACKET) && for_us
                    && !r_found && !full;

    arpc_ram #(
        .W (ENT_W),
        .D (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({r_item.src_ip, r_item.src_mac}),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stn_ip  <= '0;
            r_stn_mac <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STN_IP:  r_stn_ip  <= i_cfg_data[IP_W-1:0];
                CFG_STN_MAC: r_stn_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture and scan pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_count   <= '0;
        end else begin
            if (i_cmd.start) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end else if (i_cmd.scan) begin
                // read data is registered: it arrives in the cycle after its address
                r_cmp_vld <= issue;
                if (issue) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                if (hit && !r_found) begin
                    r_found <= 1'b1;
                end
            end
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && hit && !r_found) begin
            r_found_mac <= rd_data[MAC_W-1:0];
        end
    end

    // result
    always_comb begin
        n_out = '0;
        priority if (r_item.command == CMD_RESOLVE) begin
            if (r_found) begin
                n_out.status       = ST_HIT;
                n_out.resolved_mac = r_found_mac;
            end else begin
                n_out.status = ST_MISS;
            end
        end else if (!for_us) begin
            n_out.status = ST_IGNORED;
        end else if (!r_found && full) begin
            n_out.status = ST_FULL;
        end else if (r_item.arp_opcode == OP_REQUEST) begin
            n_out.status              = ST_REPLY;
            n_out.reply_hardware_type = r_item.hardware_type;
            n_out.reply_target_mac    = r_item.src_mac;
            n_out.reply_target_ip     = r_item.src_ip;
        end else begin
            n_out.status = ST_LEARNED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_data       = r_out;
    assign o_stat.skip      = (r_item.command == CMD_PACKET) && !for_us;
    assign o_stat.hit       = hit || r_found;
    assign o_stat.scan_done = !r_cmp_vld && (r_rd_idx >= r_count) && i_cmd.scan;
    assign o_stat.out_free  = !r_out_vld || !i_out_stall;

endmodule

// ===== rtl/arp_responder_with_cache.sv =====
// ARP responder with a learned IP-to-MAC cache. One item is worked on at a
// time; a new item is taken in the cycle after the previous result has been
// loaded into the output register. A packet not addressed to this station, or
// any item while the table is empty, has its result formed without reading
// the table. Otherwise the cache table, a RAM with registered read, is swept
// one entry per cycle in insertion order until the first match or the end
// of the filled entries. A stalled result keeps the input held off until the
// output register frees.
// ----------------------------------------------------------------------------
// arp_responder_with_cache
// Top level: ARP packet handling and IP resolve against an append-only cache.
// ----------------------------------------------------------------------------
module arp_responder_with_cache
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [MAC_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    arpc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// ===== rtl/arpc_checker.sv =====
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the ARP responder, bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker
    import arpc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_item        o_out_data
);

    // a result waiting on the consumer stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // one item at a time: an accepted item closes the input
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after an accepted item");

    // reply fields only carry data on a reply
    a_reply_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_REPLY) |->
        (o_out_data.reply_hardware_type == '0) && (o_out_data.reply_target_mac == '0)
        && (o_out_data.reply_target_ip == '0))
        else $error("reply fields set without a reply");

    // resolved mac only carries data on a hit
    a_mac_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_HIT) |-> (o_out_data.resolved_mac == '0))
        else $error("resolved mac set without a hit");

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
